>>> src/nrgd_pkg.sv
// Shared types and constants for the nibble run-length glyph decoder.
// No dependencies; imported by the controller, the datapath and the top level.
package nrgd_pkg;

  localparam int SYM_BITS  = 4;
  localparam int SYM_HALF  = 1 << (SYM_BITS - 1);
  localparam int SYM_FULL  = 1 << SYM_BITS;
  localparam int COORD_W   = 7;
  localparam int CNT_W     = SYM_BITS;
  localparam int REG_IDX_W = 2;
  localparam int CFG_W     = COORD_W;

  // configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_GLYPH_WIDTH  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_GLYPH_HEIGHT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_COLUMN_MAJOR = 2'd2;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_RUN    = 2'd1,
    PH_LIT    = 2'd2
  } phase_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EMIT = 1'b1
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic take;    // input beat accepted
    logic emit;    // load one pixel into the output register
    logic cfg_wr;  // configuration beat accepted
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic go_emit;    // accepted nibble starts a pixel burst
    logic burst_end;  // pixel being emitted ends the burst
    logic slot_free;  // output register can take a pixel this cycle
    logic out_busy;   // output register still holds a pixel
  } dp_status_t;

endpackage

>>> src/nibble_rle_glyph_decoder_top.sv
// Top level of the nibble run-length glyph decoder.
// Depends on nrgd_pkg, nrgd_ctrl and nrgd_datapath.
//
//   channel | handshake              | payload
//   --------+------------------------+-------------------------------
//   in      | in_valid_i / in_stall_o | nibble_i
//   out     | out_valid_o / out_stall_i | pixel_o, col_o, row_o, last_o
//   cfg     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// A header nibble is taken on its own. A run value or literal nibble is accepted
// and then emits its pixels (1 to 8 for a run, 1 for a literal); the single output
// register sets the one-pixel-per-cycle pace while the output does not stall.
// Reset (rst_ni low, asynchronous) clears the geometry and decoder state and rearms.
// Output stalls hold the burst; input is taken only between bursts, and
// configuration only while no pixel is pending and no nibble beat is offered.
module nibble_rle_glyph_decoder_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [nrgd_pkg::SYM_BITS-1:0]   nibble_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [nrgd_pkg::SYM_BITS-1:0]   pixel_o,
  output logic [nrgd_pkg::COORD_W-1:0]    col_o,
  output logic [nrgd_pkg::COORD_W-1:0]    row_o,
  output logic                            last_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [nrgd_pkg::REG_IDX_W-1:0]  cfg_index_i,
  input  logic [nrgd_pkg::CFG_W-1:0]      cfg_data_i
);
  import nrgd_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t status;

  nrgd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .cfg_valid_i (cfg_valid_i),
    .status_i    (status),
    .cmd_o       (cmd),
    .in_stall_o  (in_stall_o),
    .cfg_ready_o (cfg_ready_o)
  );

  nrgd_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .nibble_i    (nibble_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .pixel_o     (pixel_o),
    .col_o       (col_o),
    .row_o       (row_o),
    .last_o      (last_o)
  );

endmodule

>>> src/nrgd_ctrl.sv
// Sequencing FSM of the glyph decoder: accepts nibbles, paces pixel bursts.
// Depends on nrgd_pkg.
module nrgd_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                cfg_valid_i,
  input  nrgd_pkg::dp_status_t status_i,
  output nrgd_pkg::ctl_cmd_t   cmd_o,
  output logic                in_stall_o,
  output logic                cfg_ready_o
);
  import nrgd_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && status_i.go_emit) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status_i.slot_free && status_i.burst_end) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    cfg_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o   = 1'b0;
        // hold configuration while a nibble beat is offered
        cfg_ready_o  = !status_i.out_busy && !in_valid_i;
        cmd_o.take   = in_valid_i;
        cmd_o.cfg_wr = cfg_valid_i && !status_i.out_busy && !in_valid_i;
      end
      ST_EMIT: begin
        cmd_o.emit = status_i.slot_free;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

endmodule

>>> src/nrgd_datapath.sv
// Decoder state, pixel position stepping and the output register.
// Depends on nrgd_pkg; driven by nrgd_ctrl commands.
module nrgd_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  nrgd_pkg::ctl_cmd_t              cmd_i,
  output nrgd_pkg::dp_status_t            status_o,
  input  logic [nrgd_pkg::SYM_BITS-1:0]   nibble_i,
  input  logic [nrgd_pkg::REG_IDX_W-1:0]  cfg_index_i,
  input  logic [nrgd_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic                            out_stall_i,
  output logic                            out_valid_o,
  output logic [nrgd_pkg::SYM_BITS-1:0]   pixel_o,
  output logic [nrgd_pkg::COORD_W-1:0]    col_o,
  output logic [nrgd_pkg::COORD_W-1:0]    row_o,
  output logic                            last_o
);
  import nrgd_pkg::*;

  logic [COORD_W-1:0]  width_q, height_q;
  logic                colmaj_q;
  phase_e              phase_q, phase_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [COORD_W-1:0]  col_q, col_d, row_q, row_d;
  logic [CNT_W-1:0]    burst_q, burst_d;
  logic                lit_q, lit_d;
  logic [SYM_BITS-1:0] sym_q, sym_d;

  logic                out_valid_q;
  logic [SYM_BITS-1:0] out_pixel_q;
  logic [COORD_W-1:0]  out_col_q, out_row_q;
  logic                out_last_q;

  logic               zero_dim;
  logic               is_run, is_lit;
  logic [COORD_W:0]   col_inc, row_inc;
  logic               line_end, is_last;
  logic [COORD_W-1:0] col_next, row_next;
  logic               cfg_hit;

  assign zero_dim = (width_q == '0) || (height_q == '0);
  assign is_run   = (phase_q == PH_RUN);
  assign is_lit   = (phase_q == PH_LIT);
  assign cfg_hit  = (cfg_index_i == REG_GLYPH_WIDTH) || (cfg_index_i == REG_GLYPH_HEIGHT)
                 || (cfg_index_i == REG_COLUMN_MAJOR);

  // position stepping for the pixel at (col_q, row_q)
  always_comb begin
    col_inc  = {1'b0, col_q} + 1'b1;
    row_inc  = {1'b0, row_q} + 1'b1;
    col_next = col_q;
    row_next = row_q;
    if (colmaj_q) begin
      line_end = row_inc >= {1'b0, height_q};
      is_last  = line_end && (col_inc >= {1'b0, width_q});
      if (line_end) begin
        row_next = '0;
        col_next = col_inc[COORD_W-1:0];
      end else begin
        row_next = row_inc[COORD_W-1:0];
      end
    end else begin
      line_end = col_inc >= {1'b0, width_q};
      is_last  = line_end && (row_inc >= {1'b0, height_q});
      if (line_end) begin
        col_next = '0;
        row_next = row_inc[COORD_W-1:0];
      end else begin
        col_next = col_inc[COORD_W-1:0];
      end
    end
  end

  assign status_o.go_emit   = !zero_dim && (is_run || is_lit);
  assign status_o.burst_end = is_last || (burst_q == CNT_W'(1));
  assign status_o.slot_free = !out_valid_q || !out_stall_i;
  assign status_o.out_busy  = out_valid_q;

  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    col_d   = col_q;
    row_d   = row_q;
    burst_d = burst_q;
    lit_d   = lit_q;
    sym_d   = sym_q;
    if (cmd_i.cfg_wr) begin
      if (cfg_hit) begin
        phase_d = PH_HEADER;
        count_d = '0;
        col_d   = '0;
        row_d   = '0;
      end
    end else if (cmd_i.take && !zero_dim) begin
      case (phase_q)
        PH_RUN: begin
          sym_d   = nibble_i;
          burst_d = count_q;
          lit_d   = 1'b0;
          phase_d = PH_HEADER;
          count_d = '0;
        end
        PH_LIT: begin
          sym_d   = nibble_i;
          burst_d = CNT_W'(1);
          lit_d   = 1'b1;
        end
        default: begin
          if (nibble_i < SYM_BITS'(SYM_HALF)) begin
            phase_d = PH_RUN;
            count_d = nibble_i + 1'b1;
          end else begin
            phase_d = PH_LIT;
            count_d = CNT_W'(SYM_FULL - int'(nibble_i));
          end
        end
      endcase
    end else if (cmd_i.emit) begin
      burst_d = burst_q - 1'b1;
      if (is_last) begin
        // glyph done: rearm and drop the rest of the burst
        phase_d = PH_HEADER;
        count_d = '0;
        col_d   = '0;
        row_d   = '0;
      end else begin
        col_d = col_next;
        row_d = row_next;
        if (lit_q) begin
          count_d = count_q - 1'b1;
          if (count_q == CNT_W'(1)) begin
            phase_d = PH_HEADER;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= '0;
      height_q    <= '0;
      colmaj_q    <= 1'b0;
      phase_q     <= PH_HEADER;
      count_q     <= '0;
      col_q       <= '0;
      row_q       <= '0;
      burst_q     <= '0;
      lit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      count_q <= count_d;
      col_q   <= col_d;
      row_q   <= row_d;
      burst_q <= burst_d;
      lit_q   <= lit_d;
      if (cmd_i.cfg_wr) begin
        case (cfg_index_i)
          REG_GLYPH_WIDTH:  width_q  <= cfg_data_i;
          REG_GLYPH_HEIGHT: height_q <= cfg_data_i;
          REG_COLUMN_MAJOR: colmaj_q <= cfg_data_i[0];
          default:          ;
        endcase
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    sym_q <= sym_d;
    if (cmd_i.emit) begin
      out_pixel_q <= sym_q;
      out_col_q   <= col_q;
      out_row_q   <= row_q;
      out_last_q  <= is_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_o     = out_pixel_q;
  assign col_o       = out_col_q;
  assign row_o       = out_row_q;
  assign last_o      = out_last_q;

`ifndef ASSERT_OFF
  a_last_rearms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit && is_last |=> (col_q == '0) && (row_q == '0) && (phase_q == PH_HEADER))
    else $error("decoder did not rearm after the final pixel");
  a_pixel_in_box: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_col_q < width_q) && (out_row_q < height_q))
    else $error("pixel position outside the glyph");
  a_burst_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (burst_q != '0))
    else $error("pixel emitted with an empty burst");
  a_lit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_LIT) |-> (count_q != '0))
    else $error("literal phase with zero nibbles owed");
`endif

endmodule
